@@ sv/frms_pkg.sv @@
package frms_pkg;

	typedef struct packed {
		logic [63:0] source_frequency;
		logic [63:0] target_frequency;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] multiplier;
		logic [6:0]  shift;
		logic        bad_input;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic search_step;
		logic div_step;
		logic store;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_bad;
		logic search_done;
		logic div_last;
	} dp_status_t;

endpackage

@@ sv/frms_stream_if.sv @@
interface frms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/frms_dp.sv @@
module frms_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frms_pkg::ctrl_cmd_t  cmd,
	input  frms_pkg::in_beat_t   in_beat,
	output frms_pkg::dp_status_t status,
	output frms_pkg::out_beat_t  out_beat
);
	logic [127:0] num_q;
	logic [63:0]  src_q;
	logic [6:0]   p_q;
	logic [5:0]   div_cnt_q;
	logic         bad_q;
	logic [63:0]  out_mult_q;
	logic [6:0]   out_shift_q;
	logic         out_bad_q;
	logic [63:0]  next_hi;
	logic [63:0]  rem_shift;
	logic         take;

	assign next_hi = num_q[126:63];
	assign rem_shift = {num_q[126:64], num_q[63]};
	assign take = num_q[127] || (rem_shift >= src_q);

	assign status.in_bad = (in_beat.source_frequency == 64'd0) ||
		(in_beat.target_frequency == 64'd0);
	assign status.search_done = num_q[127] || (next_hi >= src_q);
	assign status.div_last = (div_cnt_q == 6'd63);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= 6'd0;
		end else if (cmd.load) begin
			div_cnt_q <= 6'd0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= in_beat.source_frequency;
			p_q <= 7'd0;
			bad_q <= status.in_bad;
			if (status.in_bad) begin
				num_q <= 128'd0;
			end else begin
				num_q <= {64'd0, in_beat.target_frequency};
			end
		end else if (cmd.search_step) begin
			num_q <= {num_q[126:0], 1'b0};
			p_q <= p_q + 7'd1;
		end else if (cmd.div_step) begin
			if (take) begin
				num_q <= {rem_shift - src_q, num_q[62:0], 1'b1};
			end else begin
				num_q <= {rem_shift, num_q[62:0], 1'b0};
			end
		end
		if (cmd.store) begin
			out_mult_q <= num_q[63:0];
			out_shift_q <= p_q;
			out_bad_q <= bad_q;
		end
	end

	assign out_beat.multiplier = out_mult_q;
	assign out_beat.shift = out_shift_q;
	assign out_beat.bad_input = out_bad_q;
endmodule

@@ sv/frms_ctrl.sv @@
module frms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  frms_pkg::dp_status_t status,
	output frms_pkg::ctrl_cmd_t  cmd
);
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DIV    = 2'd2;
	localparam logic [1:0] ST_STORE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = status.in_bad ? ST_STORE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.search_done) begin
					state_d = ST_DIV;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				if (out_free) begin
					cmd.store = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.store) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

@@ sv/freq_ratio_mult_shift_core.sv @@
// Computes a 64-bit multiplier and a shift so that a count t at the source
// frequency converts to the target frequency as (t * multiplier) >> shift.
// Items are processed one at a time: after a request beat is accepted, a
// shift search advances one bit position per cycle, a restoring divider
// then computes the 64-bit quotient, and a store step moves the result into
// the output register, which makes the result beat valid. The next request
// beat can be accepted in the same cycle that result beat becomes valid. A
// zero frequency skips both loops and goes straight to the store step,
// yielding a result beat with bad_input set. The output register lets a new
// request be accepted while the previous result beat is still waiting to be
// taken; if that beat is still waiting when the next result is ready, the
// block holds the new result in the store step until the output register
// is free.
module freq_ratio_mult_shift_core (
	input  logic         clk,
	input  logic         arst_n,
	frms_stream_if.sink  request,
	frms_stream_if.source result
);
	frms_pkg::ctrl_cmd_t  cmd;
	frms_pkg::dp_status_t status;
	frms_pkg::in_beat_t   in_beat;
	frms_pkg::out_beat_t  out_beat;

	assign in_beat = request.payload;
	assign result.payload = out_beat;

	frms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	frms_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_beat  (in_beat),
		.status   (status),
		.out_beat (out_beat)
	);
endmodule

@@ dv/tb_freq_ratio_mult_shift_core.sv @@
`timescale 1ns / 100ps

module tb_freq_ratio_mult_shift_core;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 250;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_HOLD = 400;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	frms_stream_if #(.payload_t(frms_pkg::in_beat_t)) req_if ();
	frms_stream_if #(.payload_t(frms_pkg::out_beat_t)) res_if ();

	freq_ratio_mult_shift_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_if),
		.result(res_if)
	);

	frms_pkg::out_beat_t pending_ratios[$];
	int errors = 0;
	int reports = 0;
	int beats_sent = 0;
	int zero_beats = 0;
	int beats_checked = 0;
	int lowest_shift = 127;
	int highest_shift = 0;
	bit source_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold_req = 0;
	longint cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_freq_ratio_mult_shift_core: done, errors");
			$finish;
		end
	end

	function automatic frms_pkg::out_beat_t predict_ratio(input logic [63:0] src,
			input logic [63:0] dst);
		frms_pkg::out_beat_t r;
		logic [127:0] num;
		int lz;
		int top;
		int best;
		int p;
		bit stop;
		r = '0;
		if (src == 64'd0 || dst == 64'd0) begin
			r.bad_input = 1'b1;
			return r;
		end
		lz = 0;
		while (lz < 64 && !dst[63 - lz])
			lz++;
		top = lz + 64;
		best = 0;
		stop = 1'b0;
		for (p = 0; p <= top && !stop; p++) begin
			num = {64'd0, dst} << p;
			if (num[127:64] >= src)
				stop = 1'b1;
			else
				best = p;
		end
		num = {64'd0, dst} << best;
		r.multiplier = 64'(num / {64'd0, src});
		r.shift = 7'(best);
		return r;
	endfunction

	function automatic logic [63:0] random_freq();
		int sel;
		logic [63:0] v;
		sel = $urandom_range(0, 99);
		v = {$urandom(), $urandom()};
		if (sel < 3)
			v = 64'd0;
		else if (sel < 9)
			v = 64'd1 << $urandom_range(0, 63);
		else if (sel < 14)
			v = ALL_ONES >> $urandom_range(0, 63);
		else if (sel < 65)
			v = v >> $urandom_range(0, 63);
		return v;
	endfunction

	task automatic check_ratio_beat(input frms_pkg::out_beat_t got);
		frms_pkg::out_beat_t want;
		beats_checked++;
		if (pending_ratios.size() == 0) begin
			errors++;
			if (reports < REPORT_LIMIT) begin
				reports++;
				$display("unexpected result beat: mult=%h shift=%0d bad=%0b",
					got.multiplier, got.shift, got.bad_input);
			end
			return;
		end
		want = pending_ratios.pop_front();
		if (got.multiplier !== want.multiplier || got.shift !== want.shift ||
				got.bad_input !== want.bad_input) begin
			errors++;
			if (reports < REPORT_LIMIT) begin
				reports++;
				$display({"mismatch on result %0d: expected mult=%h shift=%0d bad=%0b,",
					" got mult=%h shift=%0d bad=%0b"},
					beats_checked, want.multiplier, want.shift, want.bad_input,
					got.multiplier, got.shift, got.bad_input);
			end
		end
	endtask

	task automatic send_freqs(input logic [63:0] src, input logic [63:0] dst);
		int gap;
		frms_pkg::out_beat_t want;
		gap = source_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= '{source_frequency: src, target_frequency: dst};
		do @(posedge clk); while (!req_if.ready);
		want = predict_ratio(src, dst);
		pending_ratios.push_back(want);
		beats_sent++;
		if (want.bad_input) begin
			zero_beats++;
		end else begin
			if (int'(want.shift) < lowest_shift)
				lowest_shift = want.shift;
			if (int'(want.shift) > highest_shift)
				highest_shift = want.shift;
		end
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (pending_ratios.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int pause;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold_req > 0) begin
				pause = sink_hold_req;
				sink_hold_req = 0;
			end else begin
				pause = sink_steady ? 0 : $urandom_range(0, 4);
			end
			if (pause > 0) begin
				res_if.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			check_ratio_beat(res_if.payload);
		end
	end

	task automatic test_zero_frequencies();
		send_freqs(64'd0, 64'd0);
		send_freqs(64'd0, 64'd1000000000);
		send_freqs(64'd19200000, 64'd0);
		send_freqs(64'd0, ALL_ONES);
		send_freqs(ALL_ONES, 64'd0);
	endtask

	task automatic test_extremes();
		send_freqs(64'd1, 64'd1);
		send_freqs(ALL_ONES, ALL_ONES);
		send_freqs(64'd1, ALL_ONES);
		send_freqs(ALL_ONES, 64'd1);
		send_freqs(64'd1, 64'h8000_0000_0000_0000);
		send_freqs(64'h8000_0000_0000_0000, 64'd1);
		send_freqs(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		send_freqs(64'd3, 64'd1);
		send_freqs(64'd10, 64'd7);
		send_freqs(64'd7, 64'd10);
		send_freqs(64'd19200000, 64'd1000000000);
		send_freqs(64'd1000000000, 64'd19200000);
		send_freqs(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_freqs(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
	endtask

	task automatic test_random_ratios(input int count);
		repeat (count) send_freqs(random_freq(), random_freq());
	endtask

	task automatic test_back_to_back();
		source_steady = 1'b1;
		sink_steady = 1'b1;
		test_random_ratios(40);
		source_steady = 1'b0;
		sink_steady = 1'b0;
	endtask

	// The sink holds off after its next beat while the source keeps offering,
	// so the output register fills and the request side backs up.
	task automatic test_sink_hold();
		wait_drained();
		sink_hold_req = LONG_HOLD;
		source_steady = 1'b1;
		test_random_ratios(12);
		source_steady = 1'b0;
		wait_drained();
	endtask

	task automatic test_pause_between_bursts();
		repeat (3) begin
			test_random_ratios($urandom_range(5, 15));
			wait_drained();
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.payload <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_frequencies();
		test_extremes();
		test_back_to_back();
		test_sink_hold();
		test_pause_between_bursts();
		test_random_ratios(RANDOM_ITEMS);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_ratios.size() != 0)
			errors++;
		$display("sent %0d request beats (%0d with a zero frequency), checked %0d results",
			beats_sent, zero_beats, beats_checked);
		$display({"shifts seen from %0d to %0d,",
			" with back-to-back, long sink hold and drained pauses"},
			lowest_shift, highest_shift);
		if (errors == 0) begin
			$display("tb_freq_ratio_mult_shift_core: done, clean");
		end else begin
			$display("tb_freq_ratio_mult_shift_core: done, errors");
		end
		$finish;
	end

endmodule
